// ===== src/otb_pkg.sv =====
// Shared types and constants for the one-shot timer bank.
// No dependencies; every other file in src imports this package.
package otb_pkg;

    localparam int SLOTS       = 16;
    localparam int COUNT_WIDTH = 16;
    localparam int TAG_W       = 16;
    localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    // slot number widened so that its low four bits always exist
    localparam int SLOT_XW     = (SLOT_W > 4) ? SLOT_W : 4;

    typedef enum logic [1:0] {
        ST_ADDED  = 2'd0,
        ST_FULL   = 2'd1,
        ST_EXPIRE = 2'd2,
        ST_NONE   = 2'd3
    } t_status;

    localparam logic KIND_ADD  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // one timer as it travels along the cell row
    typedef struct packed {
        logic                   valid;
        logic [SLOT_W-1:0]      slot;
        logic [COUNT_WIDTH-1:0] count;
        logic [TAG_W-1:0]       tag;
        logic                   notify;
    } t_entry;

    // per-cell control: rotate toward the head, or take the insert wave
    typedef struct packed {
        logic rot;
        logic ins;
    } t_cell_ctl;

    // allocator answer
    typedef struct packed {
        logic              full;
        logic [SLOT_W-1:0] slot;
    } t_alloc;

endpackage

// ===== src/otb_cell.sv =====
// One cell of the age-ordered timer row: holds one entry.
// Depends on otb_pkg (t_entry, t_cell_ctl).
module otb_cell import otb_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_entry    i_prev,
    input  t_entry    i_next,
    output logic      o_ins_out,
    output t_entry    o_entry
);

    logic   r_valid, n_valid;
    t_entry r_data, n_data;

    // rotate takes the neighbor toward the tail, insert the one toward the head
    always_comb begin
        n_valid = r_valid;
        n_data  = r_data;
        if (i_ctl.rot) begin
            n_valid = i_next.valid;
            n_data  = i_next;
        end else if (i_ctl.ins) begin
            n_valid = i_prev.valid;
            n_data  = i_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    // insert wave goes on only past occupied cells; the first hole absorbs it
    assign o_ins_out = i_ctl.ins & r_valid;

    always_comb begin
        o_entry       = r_data;
        o_entry.valid = r_valid;
    end

endmodule

// ===== src/otb_free_find.sv =====
// Lowest free slot finder over the slot occupancy map.
// Depends on otb_pkg (t_alloc, SLOTS).
module otb_free_find import otb_pkg::*; (
    input  logic [SLOTS-1:0] i_live,
    output t_alloc           o_alloc
);

    // priority encode the lowest clear bit
    always_comb begin
        o_alloc.full = &i_live;
        o_alloc.slot = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!i_live[i]) begin
                o_alloc.slot = SLOT_W'(i);
            end
        end
    end

endmodule

// ===== src/one_shot_timer_bank_unit.sv =====
// Top level of the one-shot timer bank: cell row, allocator, scan control.
// Depends on otb_pkg, otb_cell, otb_free_find.
//
//   channel | valid       | ready       | payload
//   --------+-------------+-------------+-------------------------------------
//   input   | i_in_valid  | o_in_ready  | i_kind i_delay i_tag i_notify
//   output  | o_out_valid | i_out_ready | o_status o_slot o_expired_tag o_last
//
// An add is answered with one registered result beat. A tick rotates the cell
// row once around, newest first, one cell per cycle, then closes the result run.
// Each scan step waits while the output register holds an untaken beat, so a
// stalled output stretches the tick by the stall length.
// Reset clears the cell valid bits and the occupancy map.
module one_shot_timer_bank_unit import otb_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic                   i_kind,
    input  logic [15:0]            i_delay,
    input  logic [TAG_W-1:0]       i_tag,
    input  logic                   i_notify,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [1:0]             o_status,
    output logic [3:0]             o_slot,
    output logic [TAG_W-1:0]       o_expired_tag,
    output logic                   o_last
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    t_state             r_state, n_state;
    logic [SLOT_W-1:0]  r_step, n_step;
    logic [SLOTS-1:0]   r_live, n_live;

    // output register
    logic               r_out_valid, n_out_valid;
    t_status            r_out_status, n_out_status;
    logic [SLOT_W-1:0]  r_out_slot, n_out_slot;
    logic [TAG_W-1:0]   r_out_tag, n_out_tag;
    logic               r_out_last, n_out_last;

    // expiry held back until we know whether another follows
    logic               r_pend_valid, n_pend_valid;
    logic [SLOT_W-1:0]  r_pend_slot, n_pend_slot;
    logic [TAG_W-1:0]   r_pend_tag, n_pend_tag;

    logic               out_free, in_go, add_go, step_go;
    logic               head_expire, head_emit;
    t_alloc             alloc;
    t_entry             new_entry, proc_entry, head;
    t_entry             cell_out [SLOTS];
    logic               ins_chain [SLOTS];
    logic [SLOT_XW-1:0] slot_ext;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && out_free;
    assign in_go      = i_in_valid && o_in_ready;
    assign add_go     = in_go && (i_kind == KIND_ADD) && !alloc.full;
    assign step_go    = (r_state == S_SCAN) && out_free;

    otb_free_find u_free_find (
        .i_live  (r_live),
        .o_alloc (alloc)
    );

    // entry written by an add
    always_comb begin
        new_entry.valid  = 1'b1;
        new_entry.slot   = alloc.slot;
        new_entry.count  = COUNT_WIDTH'(i_delay);
        new_entry.tag    = i_tag;
        new_entry.notify = i_notify;
    end

    // head cell is visited and rejoins the row at the tail
    assign head        = cell_out[0];
    assign head_expire = head.valid && (head.count == '0);
    assign head_emit   = head_expire && head.notify;

    always_comb begin
        proc_entry = head;
        if (head_expire) begin
            proc_entry.valid = 1'b0;
        end else if (head.valid) begin
            proc_entry.count = head.count - COUNT_WIDTH'(1);
        end
    end

    // cell row
    assign ins_chain[0] = add_go;
    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        t_cell_ctl ctl;
        t_entry    prev_e, next_e;
        assign ctl = {step_go, ins_chain[g]};
        if (g == 0) begin : g_head
            assign prev_e = new_entry;
        end else begin : g_mid_prev
            assign prev_e = cell_out[g-1];
        end
        if (g == SLOTS - 1) begin : g_tail
            assign next_e = proc_entry;
            otb_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_ctl     (ctl),
                .i_prev    (prev_e),
                .i_next    (next_e),
                .o_ins_out (),
                .o_entry   (cell_out[g])
            );
        end else begin : g_body
            assign next_e = cell_out[g+1];
            otb_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_ctl     (ctl),
                .i_prev    (prev_e),
                .i_next    (next_e),
                .o_ins_out (ins_chain[g+1]),
                .o_entry   (cell_out[g])
            );
        end
    end

    // sequencing, occupancy map, result run
    always_comb begin
        n_state      = r_state;
        n_step       = r_step;
        n_live       = r_live;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_status = r_out_status;
        n_out_slot   = r_out_slot;
        n_out_tag    = r_out_tag;
        n_out_last   = r_out_last;
        n_pend_valid = r_pend_valid;
        n_pend_slot  = r_pend_slot;
        n_pend_tag   = r_pend_tag;

        unique case (r_state)
            S_IDLE: begin
                if (in_go) begin
                    if (i_kind == KIND_TICK) begin
                        n_state      = S_SCAN;
                        n_step       = '0;
                        n_pend_valid = 1'b0;
                    end else begin
                        n_out_valid = 1'b1;
                        n_out_last  = 1'b1;
                        n_out_tag   = '0;
                        if (alloc.full) begin
                            n_out_status = ST_FULL;
                            n_out_slot   = '0;
                        end else begin
                            n_out_status = ST_ADDED;
                            n_out_slot   = alloc.slot;
                            n_live[alloc.slot] = 1'b1;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (step_go) begin
                    if (head_expire) begin
                        n_live[head.slot] = 1'b0;
                    end
                    if (head_emit) begin
                        // earlier expiry now known not to be the last one
                        if (r_pend_valid) begin
                            n_out_valid  = 1'b1;
                            n_out_status = ST_EXPIRE;
                            n_out_slot   = r_pend_slot;
                            n_out_tag    = r_pend_tag;
                            n_out_last   = 1'b0;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_slot  = head.slot;
                        n_pend_tag   = head.tag;
                    end
                    if (r_step == SLOT_W'(SLOTS - 1)) begin
                        n_state = S_FIN;
                    end else begin
                        n_step = r_step + SLOT_W'(1);
                    end
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_last  = 1'b1;
                    if (r_pend_valid) begin
                        n_out_status = ST_EXPIRE;
                        n_out_slot   = r_pend_slot;
                        n_out_tag    = r_pend_tag;
                    end else begin
                        n_out_status = ST_NONE;
                        n_out_slot   = '0;
                        n_out_tag    = '0;
                    end
                    n_pend_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_step       <= '0;
            r_live       <= '0;
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_step       <= n_step;
            r_live       <= n_live;
            r_out_valid  <= n_out_valid;
            r_pend_valid <= n_pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_status <= n_out_status;
        r_out_slot   <= n_out_slot;
        r_out_tag    <= n_out_tag;
        r_out_last   <= n_out_last;
        r_pend_slot  <= n_pend_slot;
        r_pend_tag   <= n_pend_tag;
    end

    // ports
    assign slot_ext      = SLOT_XW'(r_out_slot);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_slot        = slot_ext[3:0];
    assign o_expired_tag = r_out_tag;
    assign o_last        = r_out_last;

endmodule

// ===== src/otb_checker.sv =====
// Port-level checks for the one-shot timer bank, bound to the top level.
// Depends on otb_pkg (status codes) and one_shot_timer_bank_unit.
module otb_checker import otb_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [1:0] o_status,
    input logic [3:0] o_slot,
    input logic [TAG_W-1:0] o_expired_tag,
    input logic       o_last
);

    // an untaken result beat stays up
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result beat dropped before it was taken");

    // no new input while a result beat is stalled
    a_no_accept_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input ready while output stalled");

    // add answers are single-beat runs with no tag
    a_add_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_ADDED || o_status == ST_FULL)
        |-> o_last && (o_expired_tag == '0))
        else $error("add result not a closed single beat");

    // idle tick closes its run with zero fields
    a_none_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_NONE)
        |-> o_last && (o_slot == 4'd0) && (o_expired_tag == '0))
        else $error("no-expiry beat malformed");

endmodule

bind one_shot_timer_bank_unit otb_checker u_otb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_status      (o_status),
    .o_slot        (o_slot),
    .o_expired_tag (o_expired_tag),
    .o_last        (o_last)
);
